// ===== rtl/kfct_pkg.sv =====
package kfct_pkg;
  localparam int unsigned TrackDepth = 1024;
  localparam int unsigned FrameW     = 10;
  localparam int unsigned WordW      = 32;
  localparam int unsigned PresW      = 32;
  localparam int unsigned PresRows   = TrackDepth / PresW;
  localparam int unsigned RowW       = 5;

  typedef enum logic [2:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_MOVE   = 3'd2,
    MODE_RESIZE = 3'd3,
    MODE_RGB    = 3'd4,
    MODE_BGR    = 3'd5,
    MODE_PREV   = 3'd6,
    MODE_NEXT   = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_e;

  // divider request and reply between sequencer and divider
  typedef struct packed {
    logic        go;
    logic [17:0] num;
    logic [9:0]  den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [17:0] quo;
    logic [9:0]  rem;
  } div_rsp_t;
endpackage

// ===== rtl/kfct_ram.sv =====
module kfct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/kfct_div.sv =====
module kfct_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kfct_pkg::div_req_t  req_i,
  output kfct_pkg::div_rsp_t  rsp_o
);
  import kfct_pkg::*;

  logic [17:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;
  logic [9:0]  den_q, den_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [10:0] shifted;

  // restoring division, one quotient bit a cycle
  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[9:0], quo_q[17]};
    if (req_i.go) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[16:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[16:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd17) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[9:0];
endmodule

// ===== rtl/keyframe_color_track_top.sv =====
// a neighbor search steps through the presence rows (32 rows of 32 bits), a blend divides per channel
// throughput: one request at a time, busy is high from the accept edge until the strobe cycle
// reset: asynchronous active low, then a pass writes all 32 presence rows with busy high
// the receiver cannot stall: each result is marked by valid_o, high for a single cycle
module keyframe_color_track_top #(
  parameter int unsigned MaxFrames = 1023
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  mode_i,
  input  logic [9:0]                  frame_i,
  input  logic [9:0]                  dest_frame_i,
  input  logic [31:0]                 key_color_i,
  output logic                        valid_o,
  output logic [31:0]                 out_color_o,
  output logic [9:0]                  out_frame_o,
  output logic [1:0]                  status_o
);
  import kfct_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR = 15'h0001,
    S_IDLE  = 15'h0002,
    S_EXEC  = 15'h0004,
    S_MVCHK = 15'h0008,
    S_MVRD  = 15'h0010,
    S_MVWR  = 15'h0020,
    S_SHR0  = 15'h0040,
    S_SHR   = 15'h0080,
    S_SCMP  = 15'h0100,
    S_CONE  = 15'h0200,
    S_C0    = 15'h0400,
    S_C1    = 15'h0800,
    S_DGO   = 15'h1000,
    S_DIV   = 15'h2000,
    S_DONE  = 15'h4000
  } state_e;

  // search kinds: what to do once the neighbor search finishes
  typedef enum logic [2:0] {
    K_INTERP_UP   = 3'd0,
    K_INTERP_DOWN = 3'd1,
    K_PREV_UP     = 3'd2,
    K_PREV_DOWN   = 3'd3,
    K_LAST        = 3'd4,
    K_NEXT_UP     = 3'd5
  } kind_e;

  state_e state_q, state_d;

  // request registers
  mode_e       mode_q;
  logic [9:0]  f_q, dst_q;
  logic [31:0] col_q;
  logic [9:0]  total_q, total_d;

  // presence memory: 32 rows x 32 bits, one bit per frame
  logic             pw_en;
  logic [RowW-1:0]  pw_addr, pr_addr;
  logic [PresW-1:0] pw_data, pr_data;
  // color memory
  logic             cw_en;
  logic [9:0]       cw_addr, cr_addr;
  logic [31:0]      cw_data, cr_data;

  kfct_ram #(.Width(PresW), .Depth(PresRows)) u_pres (
    .clk_i, .we_i(pw_en), .waddr_i(pw_addr), .wdata_i(pw_data),
    .raddr_i(pr_addr), .rdata_o(pr_data)
  );
  kfct_ram #(.Width(WordW), .Depth(TrackDepth)) u_col (
    .clk_i, .we_i(cw_en), .waddr_i(cw_addr), .wdata_i(cw_data),
    .raddr_i(cr_addr), .rdata_o(cr_data)
  );

  div_req_t div_req;
  div_rsp_t div_rsp;
  kfct_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // search / working registers
  logic [RowW-1:0] row_q, row_d;      // row under scan, also clear and shrink counter
  logic [10:0] bnd_q, bnd_d;          // up: first frame to look at, down: frame above range
  logic        dir_up_q, dir_up_d;
  logic        first_q, first_d;      // bound row still to be masked
  kind_e       kind_q, kind_d;
  logic [9:0]  a0_q, a0_d, a1_q, a1_d;
  logic        has1_q, has1_d;
  logic [31:0] c0_q, c0_d, c1_q, c1_d;
  logic [31:0] res_q, res_d;
  logic [9:0]  ofr_q, ofr_d;
  logic [1:0]  st_q, st_d;
  logic [1:0]  ch_q, ch_d;
  logic        neg_q, neg_d;
  logic [7:0]  base_q, base_d;
  logic [9:0]  mvsrc_q, mvsrc_d, mvdst_q, mvdst_d;
  logic        valid_q, valid_d;

  // search launch request inside the sequencer
  logic        srch_go, srch_up;
  logic [10:0] srch_bnd;
  kind_e       srch_kind;
  logic [9:0]  srch_hi;

  // row under scan, masked to frames of interest
  logic [31:0] mask_row;
  logic        hit, scan_end;
  logic [4:0]  hit_up, hit_dn;
  logic [9:0]  hit_frame;
  logic [9:0]  hi_f;

  always_comb begin
    hi_f     = 10'(bnd_q - 11'd1);
    mask_row = pr_data;
    if (first_q) begin
      if (dir_up_q) begin
        // bound past the last frame: nothing to find
        mask_row = bnd_q[10] ? '0 : (pr_data & (32'hFFFF_FFFF << bnd_q[4:0]));
      end else begin
        mask_row = (bnd_q == '0) ? '0 : (pr_data & ~(32'hFFFF_FFFE << hi_f[4:0]));
      end
    end
    hit    = |mask_row;
    hit_up = '0;
    for (int i = 31; i >= 0; i--) if (mask_row[i]) hit_up = 5'(i);
    hit_dn = '0;
    for (int i = 0; i < 32; i++) if (mask_row[i]) hit_dn = 5'(i);
    hit_frame = {row_q, dir_up_q ? hit_up : hit_dn};
    scan_end  = dir_up_q ? (row_q == 5'd31) : (row_q == 5'd0);
  end

  // blend of one channel
  logic [7:0]  ca, cb;
  logic [8:0]  dif;
  logic [7:0]  mag;
  logic [9:0]  num_t, den;
  logic [17:0] prod;
  logic [7:0]  q8;
  logic [7:0]  chan_out;
  always_comb begin
    ca    = c0_q[{ch_q, 3'b000} +: 8];
    cb    = c1_q[{ch_q, 3'b000} +: 8];
    dif   = {1'b0, cb} - {1'b0, ca};
    mag   = dif[8] ? 8'(-dif) : dif[7:0];
    num_t = f_q - a0_q;
    den   = a1_q - a0_q;
    prod  = 18'(mag) * 18'(num_t);
    // ceiling for negative difference
    q8    = div_rsp.quo[7:0] + {7'd0, neg_q && (div_rsp.rem != '0)};
    chan_out = neg_q ? base_q - q8 : base_q + q8;
  end

  logic range_bad;
  assign range_bad = (f_q > total_q) ||
                     ((mode_q == MODE_MOVE) && (dst_q > total_q));

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    row_d    = row_q;
    bnd_d    = bnd_q;
    dir_up_d = dir_up_q;
    first_d  = first_q;
    kind_d   = kind_q;
    a0_d = a0_q; a1_d = a1_q; has1_d = has1_q;
    c0_d = c0_q; c1_d = c1_q;
    res_d = res_q; ofr_d = ofr_q; st_d = st_q;
    ch_d = ch_q; neg_d = neg_q; base_d = base_q;
    mvsrc_d = mvsrc_q; mvdst_d = mvdst_q;
    valid_d = 1'b0;
    pw_en = 1'b0; pw_addr = row_q; pw_data = pr_data;
    pr_addr = row_q;
    cw_en = 1'b0; cw_addr = mvdst_q; cw_data = cr_data;
    cr_addr = f_q;
    div_req.go = 1'b0; div_req.num = prod; div_req.den = den;
    srch_go   = 1'b0;
    srch_up   = 1'b1;
    srch_bnd  = '0;
    srch_kind = kind_q;
    srch_hi   = '0;

    unique case (state_q)
      S_CLEAR: begin
        // frame zero holds the only key, color zero
        pw_en   = 1'b1;
        pw_addr = row_q;
        pw_data = (row_q == '0) ? 32'd1 : 32'd0;
        cw_en   = (row_q == '0);
        cw_addr = '0;
        cw_data = '0;
        row_d   = row_q + 5'd1;
        if (row_q == 5'd31) state_d = S_IDLE;
      end
      S_IDLE: begin
        // fetch the row holding the requested frame
        pr_addr = frame_i[9:5];
        if (start) begin
          state_d = S_EXEC;
          res_d = '0; ofr_d = '0; st_d = ST_OK;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (mode_q)
          MODE_INSERT: begin
            if (range_bad) st_d = ST_RANGE;
            else begin
              pw_en = 1'b1; pw_addr = f_q[9:5];
              pw_data = pr_data | (32'd1 << f_q[4:0]);
              cw_en = 1'b1; cw_addr = f_q; cw_data = col_q;
            end
          end
          MODE_DELETE: begin
            if (range_bad) st_d = ST_RANGE;
            else if (f_q != '0) begin
              pw_en = 1'b1; pw_addr = f_q[9:5];
              pw_data = pr_data & ~(32'd1 << f_q[4:0]);
            end
          end
          MODE_MOVE: begin
            if (range_bad) st_d = ST_RANGE;
            else begin
              mvsrc_d = f_q; mvdst_d = dst_q;
              pr_addr = f_q[9:5];
              state_d = S_MVCHK;
            end
          end
          MODE_RESIZE: begin
            if (dst_q == '0 || 32'(dst_q) > MaxFrames) begin
              st_d = ST_BAD_LEN;
            end else if (dst_q > total_q) begin
              // grow: the key at the old end moves to the new end
              total_d = dst_q;
              mvsrc_d = total_q; mvdst_d = dst_q;
              pr_addr = total_q[9:5];
              state_d = S_MVCHK;
            end else if (dst_q < total_q) begin
              total_d = dst_q;
              pr_addr = dst_q[9:5];
              state_d = S_SHR0;
            end
          end
          MODE_RGB, MODE_BGR: begin
            if (range_bad) st_d = ST_RANGE;
            else if (pr_data[f_q[4:0]]) begin
              cr_addr = f_q;
              state_d = S_CONE;
            end else begin
              // next key above f first, then the one below
              srch_go = 1'b1; srch_up = 1'b1;
              srch_bnd = {1'b0, f_q} + 11'd1; srch_kind = K_INTERP_UP;
            end
          end
          MODE_PREV: begin
            srch_go = 1'b1; srch_up = 1'b1;
            srch_bnd = {1'b0, f_q}; srch_kind = K_PREV_UP;
          end
          MODE_NEXT: begin
            srch_go = 1'b1; srch_up = 1'b1;
            srch_bnd = {1'b0, f_q} + 11'd1; srch_kind = K_NEXT_UP;
          end
        endcase
      end
      S_MVCHK: begin
        // source row is out: absent key or move onto itself changes nothing
        if (mvsrc_q == mvdst_q || !pr_data[mvsrc_q[4:0]]) begin
          state_d = S_DONE;
        end else begin
          pw_en = 1'b1; pw_addr = mvsrc_q[9:5];
          pw_data = pr_data & ~(32'd1 << mvsrc_q[4:0]);
          cr_addr = mvsrc_q;
          state_d = S_MVRD;
        end
      end
      S_MVRD: begin
        // source color is out, destination row read sees the cleared source bit
        cw_en = 1'b1; cw_addr = mvdst_q; cw_data = cr_data;
        pr_addr = mvdst_q[9:5];
        state_d = S_MVWR;
      end
      S_MVWR: begin
        pw_en = 1'b1; pw_addr = mvdst_q[9:5];
        pw_data = pr_data | (32'd1 << mvdst_q[4:0]);
        state_d = S_DONE;
      end
      S_SHR0: begin
        // partial row keeps frames below the new length
        pw_en   = 1'b1;
        pw_addr = dst_q[9:5];
        pw_data = pr_data & ~(32'hFFFF_FFFF << dst_q[4:0]);
        row_d   = dst_q[9:5] + 5'd1;
        state_d = (dst_q[9:5] == 5'd31) ? S_DONE : S_SHR;
      end
      S_SHR: begin
        // rows above the new length are cleared whole
        pw_en   = 1'b1;
        pw_addr = row_q;
        pw_data = '0;
        row_d   = row_q + 5'd1;
        if (row_q == 5'd31) state_d = S_DONE;
      end
      S_SCMP: begin
        if (hit || scan_end) begin
          unique case (kind_q)
            K_INTERP_UP: begin
              has1_d = hit; a1_d = hit_frame;
              srch_go = 1'b1; srch_up = 1'b0;
              srch_bnd = {1'b0, f_q}; srch_kind = K_INTERP_DOWN;
            end
            K_INTERP_DOWN: begin
              a0_d = hit_frame;
              if (hit && has1_q) begin
                cr_addr = hit_frame; state_d = S_C0;
              end else if (hit) begin
                // past the last key: hold its color
                cr_addr = hit_frame; state_d = S_CONE;
              end else if (has1_q) begin
                // before the first key: the first key's color
                cr_addr = a1_q; state_d = S_CONE;
              end else begin
                // empty track
                state_d = S_DONE;
              end
            end
            K_PREV_UP: begin
              srch_go = 1'b1; srch_up = 1'b0;
              if (hit) begin
                a1_d = hit_frame;
                srch_bnd = {1'b0, hit_frame}; srch_kind = K_PREV_DOWN;
              end else begin
                srch_bnd = 11'd1024; srch_kind = K_LAST;
              end
            end
            K_PREV_DOWN: begin
              // prev before the first key gives the first key
              ofr_d = hit ? hit_frame : a1_q; state_d = S_DONE;
            end
            K_NEXT_UP: begin
              if (hit) begin
                ofr_d = hit_frame; state_d = S_DONE;
              end else begin
                srch_go = 1'b1; srch_up = 1'b0;
                srch_bnd = 11'd1024; srch_kind = K_LAST;
              end
            end
            default: begin
              ofr_d = hit ? hit_frame : 10'd0; state_d = S_DONE;
            end
          endcase
        end else begin
          // next row is read while this one is compared
          row_d   = dir_up_q ? row_q + 5'd1 : row_q - 5'd1;
          pr_addr = row_d;
          first_d = 1'b0;
        end
      end
      S_CONE: begin
        res_d   = cr_data;
        state_d = S_DONE;
      end
      S_C0: begin
        c0_d    = cr_data;
        cr_addr = a1_q;
        state_d = S_C1;
      end
      S_C1: begin
        c1_d    = cr_data;
        ch_d    = '0;
        state_d = S_DGO;
      end
      S_DGO: begin
        // launch the channel division
        div_req.go = 1'b1;
        base_d  = ca;
        neg_d   = dif[8];
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d[{ch_q, 3'b000} +: 8] = chan_out;
          ch_d    = ch_q + 2'd1;
          state_d = (ch_q == 2'd3) ? S_DONE : S_DGO;
        end
      end
      S_DONE: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (mode_q == MODE_BGR)
          res_d = {res_q[31:24], res_q[7:0], res_q[15:8], res_q[23:16]};
      end
      default: state_d = S_IDLE;
    endcase

    // start of a neighbor search: read the bound row
    if (srch_go) begin
      dir_up_d = srch_up;
      bnd_d    = srch_bnd;
      kind_d   = srch_kind;
      first_d  = 1'b1;
      srch_hi  = 10'(srch_bnd - 11'd1);
      if (srch_up) row_d = srch_bnd[10] ? 5'd31 : srch_bnd[9:5];
      else row_d = (srch_bnd == '0) ? 5'd0 : srch_hi[9:5];
      pr_addr = row_d;
      state_d = S_SCMP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      total_q <= 10'd1;
      row_q   <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
      ofr_q   <= '0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      row_q   <= row_d;
      valid_q <= valid_d;
      res_q   <= res_d;
      ofr_q   <= ofr_d;
      st_q    <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      mode_q <= mode_e'(mode_i);
      f_q    <= frame_i;
      dst_q  <= dest_frame_i;
      col_q  <= key_color_i;
    end
    bnd_q <= bnd_d; dir_up_q <= dir_up_d; first_q <= first_d; kind_q <= kind_d;
    a0_q <= a0_d; a1_q <= a1_d; has1_q <= has1_d;
    c0_q <= c0_d; c1_q <= c1_d;
    ch_q <= ch_d; neg_q <= neg_d; base_q <= base_d;
    mvsrc_q <= mvsrc_d; mvdst_q <= mvdst_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign out_color_o = res_q;
  assign out_frame_o = ofr_q;
  assign status_o    = st_q;

  ap_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != '0) else $error("frame count zero");
  ap_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  ap_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q) else $error("result strobe longer than a cycle");
  ap_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == S_IDLE) else $error("result outside idle");
  ap_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV) else $error("quotient not awaited");
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kfct_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode_i = '0;
  logic [9:0]  frame_i = '0;
  logic [9:0]  dest_frame_i = '0;
  logic [31:0] key_color_i = '0;
  logic        valid_o;
  logic [31:0] out_color_o;
  logic [9:0]  out_frame_o;
  logic [1:0]  status_o;

  keyframe_color_track_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .frame_i      (frame_i),
    .dest_frame_i (dest_frame_i),
    .key_color_i  (key_color_i),
    .valid_o      (valid_o),
    .out_color_o  (out_color_o),
    .out_frame_o  (out_frame_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one expected result per accepted request
  typedef struct {
    logic [31:0] color;
    logic [9:0]  frame;
    status_e     status;
  } track_result_t;

  // mirror of the track contents, predicts each result from the request
  class track_scoreboard;
    bit          present[TrackDepth];
    logic [31:0] colors[TrackDepth];
    int          total;
    track_result_t pending[$];
    int          errors;

    function new();
      foreach (present[i]) begin
        present[i] = 1'b0;
        colors[i]  = '0;
      end
      present[0] = 1'b1;
      total = 1;
      errors = 0;
    endfunction

    // first key at or after from, -1 if none
    function int key_at_or_after(int from);
      for (int i = from; i < TrackDepth; i++) if (present[i]) return i;
      return -1;
    endfunction

    // last key strictly below below_f, -1 if none
    function int key_below(int below_f);
      for (int i = below_f - 1; i >= 0; i--) if (present[i]) return i;
      return -1;
    endfunction

    function logic [7:0] blend(logic [7:0] c0, logic [7:0] c1, int num_t, int den);
      int diff;
      int q;
      diff = int'(c1) - int'(c0);
      if (diff >= 0) q = (diff * num_t) / den;
      else q = -(((-diff) * num_t + den - 1) / den);
      return 8'(int'(c0) + q);
    endfunction

    function logic [31:0] color_at(int f);
      int nx;
      int pv;
      logic [31:0] r;
      if (present[f]) return colors[f];
      nx = key_at_or_after(f + 1);
      pv = key_below(f);
      if (nx < 0) return (pv < 0) ? 32'h0 : colors[pv];
      if (pv < 0) return colors[nx];
      for (int c = 0; c < 4; c++)
        r[c*8 +: 8] = blend(colors[pv][c*8 +: 8], colors[nx][c*8 +: 8], f - pv, nx - pv);
      return r;
    endfunction

    function void move_key(int from, int to);
      if (from == to || !present[from]) return;
      colors[to]    = colors[from];
      present[to]   = 1'b1;
      present[from] = 1'b0;
    endfunction

    // accepted request: update the mirror and queue its result
    function void note_request(mode_e mode, int f, int d, logic [31:0] col);
      track_result_t e;
      int k;
      int b;
      int old;
      e.color = '0;
      e.frame = '0;
      e.status = ST_OK;
      case (mode)
        MODE_INSERT: begin
          if (f > total) e.status = ST_RANGE;
          else begin
            colors[f]  = col;
            present[f] = 1'b1;
          end
        end
        MODE_DELETE: begin
          if (f > total) e.status = ST_RANGE;
          else if (f != 0) present[f] = 1'b0;
        end
        MODE_MOVE: begin
          if (f > total || d > total) e.status = ST_RANGE;
          else move_key(f, d);
        end
        MODE_RESIZE: begin
          if (d < 1 || d > 1023) e.status = ST_BAD_LEN;
          else if (d > total) begin
            old = total;
            total = d;
            move_key(old, d);
          end else if (d < total) begin
            for (int i = d; i < TrackDepth; i++) present[i] = 1'b0;
            total = d;
          end
        end
        MODE_RGB, MODE_BGR: begin
          if (f > total) e.status = ST_RANGE;
          else begin
            e.color = color_at(f);
            if (mode == MODE_BGR)
              e.color = {e.color[31:24], e.color[7:0], e.color[15:8], e.color[23:16]};
          end
        end
        MODE_PREV: begin
          k = key_at_or_after(f);
          if (k >= 0) begin
            b = key_below(k);
            e.frame = 10'((b >= 0) ? b : k);
          end else begin
            k = key_below(TrackDepth);
            e.frame = (k >= 0) ? 10'(k) : 10'd0;
          end
        end
        default: begin
          k = key_at_or_after(f + 1);
          if (k < 0) k = key_below(TrackDepth);
          e.frame = (k >= 0) ? 10'(k) : 10'd0;
        end
      endcase
      pending.insert(pending.size(), e);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [31:0] col, logic [9:0] fr, logic [1:0] st);
      track_result_t e;
      if (pending.size() == 0) begin
        report("result strobe with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (col !== e.color)
        report($sformatf("color got %h want %h", col, e.color));
      if (fr !== e.frame)
        report($sformatf("frame got %0d want %0d", fr, e.frame));
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
    endtask
  endclass

  track_scoreboard sb = new();

  int idle_pct = 0;

  // results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(out_color_o, out_frame_o, status_o);
  end

  // idle the sender at random, then present a request and hold it until taken
  task automatic send_request(mode_e mode, int f, int d, logic [31:0] col);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    mode_i       <= mode;
    frame_i      <= 10'(f);
    dest_frame_i <= 10'(d);
    key_color_i  <= col;
    start        <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(mode, f, d, col);
  endtask

  // frame mostly within the track, sometimes just past it or anywhere
  function automatic int pick_frame();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(sb.total, 0);
    if (r < 90) return (sb.total < 1023) ? sb.total + 1 : 1023;
    return $urandom_range(1023);
  endfunction

  task automatic random_request();
    int r;
    int d;
    mode_e mode;
    r = $urandom_range(99);
    if (r < 25) mode = MODE_INSERT;
    else if (r < 33) mode = MODE_DELETE;
    else if (r < 41) mode = MODE_MOVE;
    else if (r < 47) mode = MODE_RESIZE;
    else if (r < 62) mode = MODE_RGB;
    else if (r < 77) mode = MODE_BGR;
    else if (r < 88) mode = MODE_PREV;
    else mode = MODE_NEXT;
    if (mode == MODE_RESIZE) begin
      r = $urandom_range(99);
      if (r < 5) d = 0;
      else if (r < 80) d = $urandom_range(60, 1);
      else if (r < 90) d = 1023;
      else d = $urandom_range(1023);
    end else begin
      d = ($urandom_range(9) == 0) ? $urandom_range(1023) : pick_frame();
    end
    send_request(mode, pick_frame(), d, $urandom());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edges of the fields and the corner cases
    send_request(MODE_RGB, 0, 0, 32'h0);                 // reset key color
    send_request(MODE_INSERT, 0, 0, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 2, 0, 32'h1234_5678);      // beyond frame count
    send_request(MODE_RESIZE, 0, 0, 32'h0);              // length below one
    send_request(MODE_INSERT, 1, 0, 32'h00FF_00FF);      // key at the end frame
    send_request(MODE_RESIZE, 0, 1023, 32'h0);           // grow moves end key
    send_request(MODE_NEXT, 0, 0, 32'h0);
    send_request(MODE_RGB, 500, 0, 32'h0);               // blend, falling channels
    send_request(MODE_BGR, 777, 0, 32'h0);
    send_request(MODE_NEXT, 1023, 0, 32'h0);             // past the last key
    send_request(MODE_PREV, 1023, 0, 32'h0);
    send_request(MODE_DELETE, 0, 0, 32'h0);              // key zero stays
    send_request(MODE_MOVE, 5, 6, 32'h0);                // absent key
    send_request(MODE_MOVE, 1023, 1023, 32'h0);          // onto itself
    send_request(MODE_MOVE, 0, 1023, 32'h0);             // onto an existing key
    send_request(MODE_RGB, 10, 0, 32'h0);                // before the first key
    send_request(MODE_PREV, 3, 0, 32'h0);                // prev before first key
    send_request(MODE_RESIZE, 0, 20, 32'h0);             // shrink drops the key
    send_request(MODE_BGR, 7, 0, 32'h0);                 // empty track
    send_request(MODE_PREV, 7, 0, 32'h0);
    send_request(MODE_NEXT, 7, 0, 32'h0);
    send_request(MODE_INSERT, 20, 0, 32'hA5C3_3C5A);
    send_request(MODE_INSERT, 4, 0, 32'h5A3C_C3A5);
    send_request(MODE_BGR, 12, 0, 32'h0);
    send_request(MODE_RGB, 21, 0, 32'h0);                // beyond frame count

    idle_pct = 18;
    repeat (550) random_request();
    idle_pct = 76;
    repeat (550) random_request();
    idle_pct = 0;
    repeat (550) random_request();
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("expected results left over");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
